@@ sv/crc8cfr_pkg.sv @@
// shared types, constants and the crc step function of the command frame receiver
package crc8cfr_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  SYNC_VALUE_RST     = 8'h00;
  localparam logic [7:0]  CRC_POLY_RST       = 8'h8C;
  localparam logic [7:0]  OP_SELECT_HIGH_RST = 8'h01;
  localparam logic [7:0]  OP_SELECT_LOW_RST  = 8'h02;
  localparam logic [7:0]  OP_TRANSFER_RST    = 8'h03;
  localparam logic [15:0] TIMEOUT_LIMIT_RST  = 16'd60000;

  typedef enum logic [2:0] {
    REG_SYNC_VALUE     = 3'd0,
    REG_CRC_POLY       = 3'd1,
    REG_OP_SELECT_HIGH = 3'd2,
    REG_OP_SELECT_LOW  = 3'd3,
    REG_OP_TRANSFER    = 3'd4,
    REG_TIMEOUT_LIMIT  = 3'd5
  } reg_addr_t;

  typedef enum logic [2:0] {
    PH_SYNC   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_SELECT_HIGH = 2'd0,
    CMD_SELECT_LOW  = 2'd1,
    CMD_TRANSFER    = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ERR_TIMEOUT  = 3'd0,
    ERR_SYNC     = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_CRC      = 3'd3,
    ERR_UNKNOWN  = 3'd4
  } err_kind_t;

  typedef enum logic [3:0] {
    EV_PAYLOAD     = 4'd0,
    EV_SEL_HIGH    = 4'd1,
    EV_SEL_LOW     = 4'd2,
    EV_TRANSFER    = 4'd3,
    EV_ERR_TIMEOUT = 4'd4,
    EV_ERR_SYNC    = 4'd5,
    EV_ERR_LENGTH  = 4'd6,
    EV_ERR_CRC     = 4'd7,
    EV_ERR_UNKNOWN = 4'd8
  } ev_code_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_value;
    logic [7:0] payload_index;
    cmd_kind_t  command_kind;
    logic [15:0] send_count;
    logic [15:0] recv_count;
    err_kind_t  error_kind;
  } out_item_t;

  typedef struct packed {
    reg_addr_t   addr;
    logic [15:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [7:0]  crc_poly;
    logic [7:0]  op_select_high;
    logic [7:0]  op_select_low;
    logic [7:0]  op_transfer;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    ev_code_t    code;
    logic [7:0]  value;
    logic [7:0]  index;
    logic [15:0] send_count;
    logic [15:0] recv_count;
  } ev_t;

  typedef struct packed {
    logic valid;
    ev_t  ev;
  } q_port_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ sv/crc8cfr_if.sv @@
// valid/ready channel interfaces for input items, results and register writes
interface crc8cfr_in_if;
  logic                  valid;
  logic                  ready;
  crc8cfr_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface crc8cfr_out_if;
  logic                   valid;
  logic                   ready;
  crc8cfr_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface crc8cfr_cfg_if;
  logic                 valid;
  logic                 ready;
  crc8cfr_pkg::cfg_wr_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ sv/crc8cfr_front.sv @@
// frame parser: accepts bytes and idle ticks, tracks the frame and classifies events
module crc8cfr_front #(
  parameter int BUFFER_BYTES = crc8cfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  crc8cfr_in_if.sink            in_ch,
  input  crc8cfr_pkg::cfg_t     cfg,
  input  logic                  q_full,
  output crc8cfr_pkg::q_port_t  q_wr
);

  crc8cfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [15:0] send_r, send_nxt;
  logic [15:0] recv_r, recv_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crc8cfr_pkg::PH_SYNC;
      crc_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      send_r  <= '0;
      recv_r  <= '0;
      idle_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      send_r  <= send_nxt;
      recv_r  <= recv_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    send_nxt  = send_r;
    recv_nxt  = recv_r;
    idle_nxt  = idle_r;
    q_wr      = '0;
    if (accept) begin
      if (in_ch.data.mode) begin
        // idle tick
        idle_nxt = idle_r + 16'd1;
        if (idle_nxt >= cfg.timeout_limit) begin
          if (phase_r != crc8cfr_pkg::PH_SYNC) begin
            q_wr.valid   = 1'b1;
            q_wr.ev.code = crc8cfr_pkg::EV_ERR_TIMEOUT;
            phase_nxt    = crc8cfr_pkg::PH_SYNC;
          end
          idle_nxt = '0;
        end
      end else begin
        idle_nxt = '0;
        unique case (phase_r)
          crc8cfr_pkg::PH_CMD: begin
            cmd_nxt   = b;
            crc_nxt   = crc8cfr_pkg::crc8_step(crc_r, b, cfg.crc_poly);
            phase_nxt = crc8cfr_pkg::PH_LEN_HI;
          end
          crc8cfr_pkg::PH_LEN_HI: begin
            crc_nxt   = crc8cfr_pkg::crc8_step(crc_r, b, cfg.crc_poly);
            len_nxt   = {b, 8'h00};
            phase_nxt = crc8cfr_pkg::PH_LEN_LO;
          end
          crc8cfr_pkg::PH_LEN_LO: begin
            len_nxt = {len_r[15:8], b};
            if (len_nxt > 16'(BUFFER_BYTES)) begin
              q_wr.valid   = 1'b1;
              q_wr.ev.code = crc8cfr_pkg::EV_ERR_LENGTH;
              phase_nxt    = crc8cfr_pkg::PH_SYNC;
            end else begin
              crc_nxt = crc8cfr_pkg::crc8_step(crc_r, b, cfg.crc_poly);
              if (len_nxt == 16'd0) begin
                phase_nxt = crc8cfr_pkg::PH_CRC;
              end else begin
                seen_nxt  = '0;
                phase_nxt = crc8cfr_pkg::PH_DATA;
              end
            end
          end
          crc8cfr_pkg::PH_DATA: begin
            if (cmd_r == cfg.op_transfer) begin
              unique case (seen_r)
                16'd0: send_nxt = {b, 8'h00};
                16'd1: send_nxt = {send_r[15:8], b};
                16'd2: recv_nxt = {b, 8'h00};
                16'd3: recv_nxt = {recv_r[15:8], b};
                default: begin
                  q_wr.valid    = 1'b1;
                  q_wr.ev.code  = crc8cfr_pkg::EV_PAYLOAD;
                  q_wr.ev.value = b;
                  q_wr.ev.index = 8'(seen_r - 16'd4);
                end
              endcase
            end
            seen_nxt = seen_r + 16'd1;
            if (seen_nxt == len_r) begin
              phase_nxt = crc8cfr_pkg::PH_CRC;
            end
            crc_nxt = crc8cfr_pkg::crc8_step(crc_r, b, cfg.crc_poly);
          end
          crc8cfr_pkg::PH_CRC: begin
            q_wr.valid = 1'b1;
            if (crc_r != b) begin
              q_wr.ev.code = crc8cfr_pkg::EV_ERR_CRC;
            end else if (cmd_r == cfg.op_select_high) begin
              q_wr.ev.code = crc8cfr_pkg::EV_SEL_HIGH;
            end else if (cmd_r == cfg.op_select_low) begin
              q_wr.ev.code = crc8cfr_pkg::EV_SEL_LOW;
            end else if (cmd_r == cfg.op_transfer) begin
              q_wr.ev.code       = crc8cfr_pkg::EV_TRANSFER;
              q_wr.ev.send_count = send_r;
              q_wr.ev.recv_count = recv_r;
            end else begin
              q_wr.ev.code = crc8cfr_pkg::EV_ERR_UNKNOWN;
            end
            phase_nxt = crc8cfr_pkg::PH_SYNC;
          end
          default: begin
            // waiting for sync, also unused phase codes
            phase_nxt = crc8cfr_pkg::PH_SYNC;
            if (b != cfg.sync_value) begin
              q_wr.valid   = 1'b1;
              q_wr.ev.code = crc8cfr_pkg::EV_ERR_SYNC;
            end else begin
              crc_nxt   = crc8cfr_pkg::crc8_step(8'h00, b, cfg.crc_poly);
              phase_nxt = crc8cfr_pkg::PH_CMD;
            end
          end
        endcase
      end
    end
  end

endmodule

@@ sv/crc8cfr_queue.sv @@
// short event queue between the frame parser and the result stage
module crc8cfr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crc8cfr_pkg::q_port_t q_wr,
  output logic                 q_full,
  output crc8cfr_pkg::q_port_t q_rd,
  input  logic                 q_pop
);

  crc8cfr_pkg::ev_t                mem_r [crc8cfr_pkg::QUEUE_DEPTH];
  logic [crc8cfr_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [crc8cfr_pkg::QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [crc8cfr_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            push;
  logic                            pop;

  assign q_full     = (cnt_r == crc8cfr_pkg::QCNT_W'(crc8cfr_pkg::QUEUE_DEPTH));
  assign push       = q_wr.valid && !q_full;
  assign pop        = q_pop && q_rd.valid;
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.ev    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + crc8cfr_pkg::QCNT_W'(push) - crc8cfr_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= q_wr.ev;
    end
  end

  // parser never offers an event while the queue is full
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n) q_wr.valid |-> !q_full)
    else $error("event offered to full queue");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not rise on push");
  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not fall on pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != crc8cfr_pkg::QCNT_W'(crc8cfr_pkg::QUEUE_DEPTH)) |->
    (wptr_r - rptr_r) == cnt_r[crc8cfr_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ sv/crc8cfr_back.sv @@
// result stage: turns queued events into result items behind an output register
module crc8cfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crc8cfr_pkg::q_port_t q_rd,
  output logic                 q_pop,
  crc8cfr_out_if.source        out_ch
);

  logic                   out_valid_r, out_valid_nxt;
  crc8cfr_pkg::out_item_t out_data_r, out_data_nxt;
  crc8cfr_pkg::out_item_t fmt;

  assign q_pop        = q_rd.valid && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    fmt = '0;
    unique case (q_rd.ev.code)
      crc8cfr_pkg::EV_PAYLOAD: begin
        fmt.kind          = crc8cfr_pkg::KIND_PAYLOAD;
        fmt.payload_value = q_rd.ev.value;
        fmt.payload_index = q_rd.ev.index;
      end
      crc8cfr_pkg::EV_SEL_HIGH: begin
        fmt.kind         = crc8cfr_pkg::KIND_COMMAND;
        fmt.command_kind = crc8cfr_pkg::CMD_SELECT_HIGH;
      end
      crc8cfr_pkg::EV_SEL_LOW: begin
        fmt.kind         = crc8cfr_pkg::KIND_COMMAND;
        fmt.command_kind = crc8cfr_pkg::CMD_SELECT_LOW;
      end
      crc8cfr_pkg::EV_TRANSFER: begin
        fmt.kind         = crc8cfr_pkg::KIND_COMMAND;
        fmt.command_kind = crc8cfr_pkg::CMD_TRANSFER;
        fmt.send_count   = q_rd.ev.send_count;
        fmt.recv_count   = q_rd.ev.recv_count;
      end
      crc8cfr_pkg::EV_ERR_TIMEOUT: begin
        fmt.kind       = crc8cfr_pkg::KIND_ERROR;
        fmt.error_kind = crc8cfr_pkg::ERR_TIMEOUT;
      end
      crc8cfr_pkg::EV_ERR_SYNC: begin
        fmt.kind       = crc8cfr_pkg::KIND_ERROR;
        fmt.error_kind = crc8cfr_pkg::ERR_SYNC;
      end
      crc8cfr_pkg::EV_ERR_LENGTH: begin
        fmt.kind       = crc8cfr_pkg::KIND_ERROR;
        fmt.error_kind = crc8cfr_pkg::ERR_LENGTH;
      end
      crc8cfr_pkg::EV_ERR_CRC: begin
        fmt.kind       = crc8cfr_pkg::KIND_ERROR;
        fmt.error_kind = crc8cfr_pkg::ERR_CRC;
      end
      crc8cfr_pkg::EV_ERR_UNKNOWN: begin
        fmt.kind       = crc8cfr_pkg::KIND_ERROR;
        fmt.error_kind = crc8cfr_pkg::ERR_UNKNOWN;
      end
      default: begin
        fmt = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fmt;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // a queued event always lands in the output register
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_valid_r)
    else $error("popped event not presented");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !q_pop)
    else $error("queue popped while result stalled");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && q_rd.valid |-> q_pop)
    else $error("empty output register left idle");

endmodule

@@ sv/crc8_command_frame_receiver_core.sv @@
// top level of the crc-8 command frame receiver: registers, parser, queue and result stage
// path: each event goes from the parser into the event queue and from there into the output register
// throughput: one item per cycle while the event queue is not full, paced by the parser and the 4-entry queue
// in_ready falls only while the event queue is full under output backpressure
// reset (rst_n low, synchronous) clears phase, counters, queue and output valid
// and loads the register reset values; no clearing pass is needed
module crc8_command_frame_receiver_core #(
  parameter int BUFFER_BYTES = crc8cfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  crc8cfr_in_if.sink      in_ch,
  crc8cfr_out_if.source   out_ch,
  crc8cfr_cfg_if.sink     cfg_ch
);

  crc8cfr_pkg::cfg_t    cfg_r, cfg_nxt;
  crc8cfr_pkg::q_port_t q_wr;
  crc8cfr_pkg::q_port_t q_rd;
  logic                 q_full;
  logic                 q_pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.addr)
        crc8cfr_pkg::REG_SYNC_VALUE:     cfg_nxt.sync_value     = cfg_ch.data.wdata[7:0];
        crc8cfr_pkg::REG_CRC_POLY:       cfg_nxt.crc_poly       = cfg_ch.data.wdata[7:0];
        crc8cfr_pkg::REG_OP_SELECT_HIGH: cfg_nxt.op_select_high = cfg_ch.data.wdata[7:0];
        crc8cfr_pkg::REG_OP_SELECT_LOW:  cfg_nxt.op_select_low  = cfg_ch.data.wdata[7:0];
        crc8cfr_pkg::REG_OP_TRANSFER:    cfg_nxt.op_transfer    = cfg_ch.data.wdata[7:0];
        crc8cfr_pkg::REG_TIMEOUT_LIMIT:  cfg_nxt.timeout_limit  = cfg_ch.data.wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value     <= crc8cfr_pkg::SYNC_VALUE_RST;
      cfg_r.crc_poly       <= crc8cfr_pkg::CRC_POLY_RST;
      cfg_r.op_select_high <= crc8cfr_pkg::OP_SELECT_HIGH_RST;
      cfg_r.op_select_low  <= crc8cfr_pkg::OP_SELECT_LOW_RST;
      cfg_r.op_transfer    <= crc8cfr_pkg::OP_TRANSFER_RST;
      cfg_r.timeout_limit  <= crc8cfr_pkg::TIMEOUT_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crc8cfr_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  crc8cfr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  crc8cfr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
